/* hdl/nev_pkg.sv */
// Shared types and constants for the numeric entity to UTF-8 decoder.
`timescale 1ns / 1ps

package nev_pkg;

  // Most bytes one input word can produce: four UTF-8 bytes plus the terminator.
  localparam int RUN_MAX   = 5;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [20:0] ACC_MAX = 21'h1FFFFF;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  // Bytes produced by one input word, in output order from index 0.
  typedef struct packed {
    logic [RUN_CNT_W-1:0]     cnt;
    logic [RUN_MAX-1:0][7:0]  bytes;
  } run_t;

endpackage

/* hdl/nev_in_reg.sv */
// Input register stage holding one accepted text byte.
`timescale 1ns / 1ps

module nev_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

/* hdl/nev_parse.sv */
// Character reference parser state and the run of output bytes for the held word.
`timescale 1ns / 1ps

module nev_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    cur_byte,
  output nev_pkg::run_t run
);
  import nev_pkg::*;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_AMP    = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  logic [1:0]           mode;
  logic [1:0]           mode_next;
  logic [20:0]          acc;
  logic [20:0]          acc_next;
  logic                 ovf;
  logic                 ovf_next;
  logic [24:0]          prod;
  logic                 is_digit;
  logic [RUN_CNT_W-1:0] enc_cnt;
  logic [3:0][7:0]      enc_b;

  assign is_digit = (cur_byte >= CH_ZERO) && (cur_byte <= CH_NINE);
  // acc*10 + digit as two shifted adds
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
              + {21'd0, cur_byte[3:0] - CH_ZERO[3:0]};

  // UTF-8 encoding of the pending code point
  always_comb begin
    enc_b = '0;
    priority if (ovf || acc > CP_MAX) begin
      enc_cnt  = RUN_CNT_W'(1);
      enc_b[0] = CH_QMARK;
    end else if (acc < 21'h80) begin
      enc_cnt  = RUN_CNT_W'(1);
      enc_b[0] = acc[7:0];
    end else if (acc < 21'h800) begin
      enc_cnt  = RUN_CNT_W'(2);
      enc_b[0] = {3'b110, acc[10:6]};
      enc_b[1] = {2'b10, acc[5:0]};
    end else if (acc < 21'h10000) begin
      enc_cnt  = RUN_CNT_W'(3);
      enc_b[0] = {4'b1110, acc[15:12]};
      enc_b[1] = {2'b10, acc[11:6]};
      enc_b[2] = {2'b10, acc[5:0]};
    end else begin
      enc_cnt  = RUN_CNT_W'(4);
      enc_b[0] = {5'b11110, acc[20:18]};
      enc_b[1] = {2'b10, acc[17:12]};
      enc_b[2] = {2'b10, acc[11:6]};
      enc_b[3] = {2'b10, acc[5:0]};
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    ovf_next  = ovf;
    run       = '0;
    unique case (mode)
      MODE_AMP: begin
        if (cur_byte == CH_HASH) begin
          mode_next = MODE_DIGITS;
          acc_next  = '0;
          ovf_next  = 1'b0;
        end else begin
          run.cnt      = RUN_CNT_W'(2);
          run.bytes[0] = CH_AMP;
          run.bytes[1] = cur_byte;
          mode_next    = MODE_NORMAL;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          if (prod > {4'd0, ACC_MAX}) begin
            acc_next = ACC_MAX;
            ovf_next = 1'b1;
          end else begin
            acc_next = prod[20:0];
          end
        end else begin
          run.bytes[3:0] = enc_b;
          run.cnt        = enc_cnt;
          if (cur_byte != CH_SEMI) begin
            run.bytes[enc_cnt] = cur_byte;
            run.cnt            = enc_cnt + RUN_CNT_W'(1);
          end
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (cur_byte == CH_AMP) begin
          mode_next = MODE_AMP;
        end else begin
          run.cnt      = RUN_CNT_W'(1);
          run.bytes[0] = cur_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= '0;
      ovf  <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      acc  <= acc_next;
      ovf  <= ovf_next;
    end
  end

`ifndef SYNTHESIS
  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    ovf |-> acc == ACC_MAX)
    else $error("overflow flag set without saturated accumulator");

  a_hash_enters_digits: assert property (@(posedge clk) disable iff (rst)
    (step && mode == MODE_AMP && cur_byte == CH_HASH)
      |=> (mode == MODE_DIGITS && acc == '0 && !ovf))
    else $error("hash after ampersand did not start a digit run");
`endif

endmodule

/* hdl/nev_emit.sv */
// Run buffer that sends one word's output bytes one per cycle while out_ready is high.
`timescale 1ns / 1ps

module nev_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  nev_pkg::run_t run,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);
  import nev_pkg::*;

  logic [RUN_CNT_W-1:0]    cnt;
  logic [RUN_CNT_W-1:0]    idx;
  logic [RUN_MAX-1:0][7:0] bytes;

  assign out_valid   = (cnt != '0);
  assign last_of_run = (idx == cnt - RUN_CNT_W'(1));
  assign out_byte    = bytes[idx];
  assign free        = !out_valid || (out_ready && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load && run.cnt != '0) begin
      cnt <= run.cnt;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      if (last_of_run) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + RUN_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && run.cnt != '0) begin
      bytes <= run.bytes;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < cnt && cnt <= RUN_CNT_W'(RUN_MAX)))
    else $error("byte index outside the buffered run");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run)
      |=> (out_valid && idx == $past(idx) + RUN_CNT_W'(1)))
    else $error("run did not advance by one byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

/* hdl/numeric_entity_to_utf8.sv */
// Top level: decimal character reference to UTF-8 stream decoder.
`timescale 1ns / 1ps

// A held word waits in the input register until the run buffer is free, then loads into it.
// Throughput: one input word per cycle while each word yields at most one byte and the
// receiver is ready; a word yielding several bytes holds the input while the run buffer
// drains them, one byte per cycle as the receiver allows. Words yielding no byte pass too.
// Reset (rst, synchronous): parser back to normal mode, accumulator cleared, no words held.
module numeric_entity_to_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import nev_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       free;
  logic       consume;
  run_t       run;

  // The held word is parsed once the run buffer can take its bytes;
  // parser state advances only then.
  assign consume = held_valid && free;

  nev_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_ready   (in_ready),
    .take       (consume),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  nev_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (consume),
    .cur_byte (held_byte),
    .run      (run)
  );

  nev_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (consume),
    .run         (run),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

/* dv/nev_checker.sv */
// Checker: predicts the decoded byte stream and compares it with the output channel.
`timescale 1ns / 1ps

module nev_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last_of_run,
  output int         fail_count,
  output int         pending
);
  import nev_pkg::*;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_AMP    = 2'd1,
    PM_DIGITS = 2'd2
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t   utf8_expected[$];
  parse_mode_t mode_q;
  logic [20:0] accum_q;
  logic        ovf_q;
  int          mismatch_total = 0;

  assign fail_count = mismatch_total;

  // Advance the parser by one input word and queue the bytes it yields.
  task automatic decode_word(input logic [7:0] b);
    logic [7:0]  run [RUN_MAX];
    int          n;
    logic [24:0] next_acc;
    logic [20:0] cp;
    out_word_t   w;
    n  = 0;
    cp = accum_q;
    case (mode_q)
      PM_AMP: begin
        if (b == CH_HASH) begin
          mode_q  = PM_DIGITS;
          accum_q = '0;
          ovf_q   = 1'b0;
        end else begin
          run[0] = CH_AMP;
          run[1] = b;
          n      = 2;
          mode_q = PM_NORMAL;
        end
      end
      PM_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          next_acc = {4'b0, accum_q} * 25'd10 + {17'b0, b - CH_ZERO};
          if (next_acc > {4'b0, ACC_MAX}) begin
            accum_q = ACC_MAX;
            ovf_q   = 1'b1;
          end else begin
            accum_q = next_acc[20:0];
          end
        end else begin
          if (ovf_q || cp > CP_MAX) begin
            run[0] = CH_QMARK;
            n      = 1;
          end else if (cp < 21'h80) begin
            run[0] = cp[7:0];
            n      = 1;
          end else if (cp < 21'h800) begin
            run[0] = 8'hC0 | {3'b0, cp[10:6]};
            run[1] = 8'h80 | {2'b0, cp[5:0]};
            n      = 2;
          end else if (cp < 21'h10000) begin
            run[0] = 8'hE0 | {4'b0, cp[15:12]};
            run[1] = 8'h80 | {2'b0, cp[11:6]};
            run[2] = 8'h80 | {2'b0, cp[5:0]};
            n      = 3;
          end else begin
            run[0] = 8'hF0 | {5'b0, cp[20:18]};
            run[1] = 8'h80 | {2'b0, cp[17:12]};
            run[2] = 8'h80 | {2'b0, cp[11:6]};
            run[3] = 8'h80 | {2'b0, cp[5:0]};
            n      = 4;
          end
          if (b != CH_SEMI) begin
            run[n] = b;
            n++;
          end
          mode_q = PM_NORMAL;
        end
      end
      default: begin
        // unused mode value behaves as normal text
        mode_q = PM_NORMAL;
        if (b == CH_AMP) begin
          mode_q = PM_AMP;
        end else begin
          run[0] = b;
          n      = 1;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      w.data = run[i];
      w.last = (i == n - 1);
      utf8_expected.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (rst) begin
      mode_q  = PM_NORMAL;
      accum_q = '0;
      ovf_q   = 1'b0;
      utf8_expected.delete();
    end else begin
      if (in_valid && in_ready) decode_word(in_byte);
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got byte %02h last %0b",
                   $time, out_byte, last_of_run);
          mismatch_total++;
        end else begin
          w = utf8_expected.pop_front();
          if (out_byte !== w.data) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, w.data, out_byte);
            mismatch_total++;
          end
          if (last_of_run !== w.last) begin
            $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                     $time, w.last, last_of_run);
            mismatch_total++;
          end
        end
      end
    end
    pending <= utf8_expected.size();
  end

endmodule

/* dv/numeric_entity_to_utf8_tb.sv */
// Testbench top: drives byte streams with character references into the decoder.
`timescale 1ns / 1ps

module numeric_entity_to_utf8_tb;
  import nev_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  // Real stalls come from random idling only.
  localparam int WATCHDOG_LIMIT = 5000;
  // Give the output some slack after the queue empties.
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_WORDS    = 76;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  int fail_count;
  int pending;

  int send_idle_pct = 36;
  int recv_idle_pct = 45;
  int words_in      = 0;
  int words_out     = 0;
  int refs_sent     = 0;
  int idle_cycles   = 0;

  numeric_entity_to_utf8 u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  nev_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: backpressure at the current idle rate, decided fresh every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any handshake on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
      if (out_valid && out_ready) words_out <= words_out + 1;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One input word. Random idle cycles go in front of it; valid is only
  // dropped in a step where it is not also raised.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_in++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // Hold off the sender until every predicted byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // A reference, mostly well-formed, with a code point drawn from each encoding class,
  // the range edges, surrogates, out-of-range values and saturating runs.
  task automatic send_random_reference();
    int unsigned cp;
    int          extra;
    int          zeros;
    logic [7:0]  term;
    extra = 0;
    zeros = 0;
    case ($urandom_range(9))
      0: cp = $urandom_range(0, 127);
      1: cp = $urandom_range(128, 2047);
      2: cp = $urandom_range(2048, 65535);
      3: cp = $urandom_range(32'hD800, 32'hDFFF);
      4: cp = $urandom_range(32'h10000, 32'h10FFFF);
      5: cp = 32'h10FFFF;
      6: cp = $urandom_range(32'h110000, 32'h1FFFFF);
      7: begin
        case ($urandom_range(6))
          0: cp = 32'h7F;
          1: cp = 32'h80;
          2: cp = 32'h7FF;
          3: cp = 32'h800;
          4: cp = 32'hFFFF;
          5: cp = 32'h10000;
          default: cp = 32'h110000;
        endcase
      end
      8: begin
        // long digit run: may saturate the accumulator
        cp    = $urandom_range(32'h1FFFFF);
        extra = $urandom_range(1, 4);
      end
      default: begin
        cp    = $urandom_range(0, 999);
        zeros = $urandom_range(1, 4);
      end
    endcase
    term = ($urandom_range(99) < 75) ? CH_SEMI : 8'($urandom_range(255));
    send_word(CH_AMP);
    send_word(CH_HASH);
    repeat (zeros) send_word(CH_ZERO);
    // empty digit run now and then
    if ($urandom_range(19) != 0) send_text($sformatf("%0d", cp));
    repeat (extra) send_word(CH_ZERO + 8'($urandom_range(9)));
    send_word(term);
    refs_sent++;
  endtask

  task automatic send_random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_random_reference();
    end else if (pick < 65) begin
      // raw noise across the whole byte range
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(255)));
    end else if (pick < 78) begin
      // lone ampersand, including a doubled one
      send_word(CH_AMP);
      send_word(($urandom_range(3) == 0) ? CH_AMP : 8'($urandom_range(255)));
    end else if (pick < 88) begin
      // broken reference: random digits, any byte as terminator
      send_word(CH_AMP);
      send_word(CH_HASH);
      repeat ($urandom_range(0, 3)) send_word(CH_ZERO + 8'($urandom_range(9)));
      send_word(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(32, 126)));
    end
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, doubled ampersand, empty digit run, the upper
    // code point limit with a kept terminator (five bytes out), and overflow.
    send_word(8'h00);
    send_word(8'hFF);
    send_text("&&");
    send_text("&#;");
    send_text("&#1114111@");
    send_text("&#9999999;");
    refs_sent += 3;

    // Three idle profiles; each starts with the sender held until drained.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 36; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_drained();
      target = words_in + PHASE_WORDS;
      while (words_in < target) send_random_sequence();
    end

    // Drain: wait for the queue to empty, then let trailing outputs show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input words, %0d character references, %0d output words,",
             words_in, refs_sent, words_out);
    $display("under three sender/receiver idle profiles with one drain pause each.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
